/* rtl/epit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epit_pkg
// Shared sizes, codes and the command/status bundles that join the
// controller and the datapath of the expiring pending-id table.
// ----------------------------------------------------------------------------
package epit_pkg;

  // Storage sizes
  localparam int TABLE_DEPTH    = 32;
  localparam int BATCH_MAX      = 16;
  localparam int SNAPSHOT_DEPTH = 128;

  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int SAW = (SNAPSHOT_DEPTH > 1) ? $clog2(SNAPSHOT_DEPTH) : 1;
  localparam int SCW = $clog2(SNAPSHOT_DEPTH + 1);
  localparam int BCW = $clog2(BATCH_MAX + 1);

  // Field widths
  localparam int OPW   = 2;
  localparam int IDW   = 32;
  localparam int NOWW  = 40;
  localparam int LIFEW = 20;
  localparam int EXPW  = 41;
  localparam int KINDW = 3;
  localparam int CNTW  = 6;
  localparam int TWW   = IDW + EXPW;
  localparam int EWW   = IDW + 1;

  localparam logic [LIFEW-1:0] LIFETIME_RESET = LIFEW'(10000);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [OPW-1:0] {
    OP_RECORD = 2'd0,
    OP_SNAP   = 2'd1,
    OP_PUMP   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [KINDW-1:0] {
    K_NONE      = 3'd0,
    K_NEW       = 3'd1,
    K_REFRESHED = 3'd2,
    K_REPLACED  = 3'd3,
    K_DEPOSIT   = 3'd4,
    K_EXPIRED   = 3'd5,
    K_IGNORED   = 3'd6,
    K_LOADED    = 3'd7
  } kind_t;

  typedef struct packed {
    logic  load_in;
    logic  set_res;
    kind_t res_kind;
    logic  snap_load;
    logic  idx_clr;
    logic  idx_inc;
    logic  min_upd;
    logic  found_set;
    logic  rec_commit;
    logic  pump_init;
    logic  ent_latch;
    logic  sidx_inc;
    logic  hit_set;
    logic  decide;
    logic  k_clr;
    logic  k_inc;
    logic  rem_latch;
    logic  rd_last;
    logic  move;
    logic  out_load;
    logic  out_emit;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic id_zero;
    logic allowed;
    logic total_zero;
    logic idx_last;
    logic match;
    logic smatch;
    logic snap_empty;
    logic sidx_last;
    logic emit_empty;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/epit_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epit_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface epit_in_if;
  logic                      valid;
  logic                      ready;
  logic [epit_pkg::OPW-1:0]  operation;
  logic [epit_pkg::IDW-1:0]  item_id;
  logic [epit_pkg::NOWW-1:0] now_ms;
  logic                      snapshot_first;
  logic                      pump_allowed;

  modport source (output valid, operation, item_id, now_ms, snapshot_first,
                  pump_allowed, input ready);
  modport sink (input valid, operation, item_id, now_ms, snapshot_first,
                pump_allowed, output ready);
endinterface

interface epit_out_if;
  logic                       valid;
  logic                       ready;
  logic [epit_pkg::KINDW-1:0] result_kind;
  logic [epit_pkg::IDW-1:0]   result_id;
  logic [epit_pkg::CNTW-1:0]  pending_count;
  logic                       last_result;

  modport source (output valid, result_kind, result_id, pending_count,
                  last_result, input ready);
  modport sink (input valid, result_kind, result_id, pending_count,
                last_result, output ready);
endinterface

/* rtl/epit_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epit_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module epit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/epit_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epit_dp
// Datapath: table, snapshot and emission memories, scan counters,
// lifetime register and the result register.
// ----------------------------------------------------------------------------
module epit_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  epit_pkg::cmd_t              cmd,
  output epit_pkg::sts_t              sts,
  input  logic [epit_pkg::OPW-1:0]    in_operation,
  input  logic [epit_pkg::IDW-1:0]    in_item_id,
  input  logic [epit_pkg::NOWW-1:0]   in_now_ms,
  input  logic                        in_snapshot_first,
  input  logic                        in_pump_allowed,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [epit_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [epit_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [epit_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [epit_pkg::KINDW-1:0]  out_result_kind,
  output logic [epit_pkg::IDW-1:0]    out_result_id,
  output logic [epit_pkg::CNTW-1:0]   out_pending_count,
  output logic                        out_last_result
);
  localparam int TAW = epit_pkg::TAW;
  localparam int TCW = epit_pkg::TCW;
  localparam int SAW = epit_pkg::SAW;
  localparam int SCW = epit_pkg::SCW;
  localparam int BCW = epit_pkg::BCW;
  localparam int IDW = epit_pkg::IDW;
  localparam int EXPW = epit_pkg::EXPW;

  // Latched item
  epit_pkg::op_t               op_r;
  logic [IDW-1:0]              id_r;
  logic [epit_pkg::NOWW-1:0]   now_r;
  logic                        first_r;
  logic                        allowed_r;
  logic [epit_pkg::LIFEW-1:0]  life_r;

  // Counts and scan state
  logic [TCW-1:0]  total_r;
  logic [SCW-1:0]  snap_total_r;
  logic [TAW-1:0]  idx_r, found_idx_r, min_idx_r, k_r;
  logic [SAW-1:0]  sidx_r;
  logic [TCW-1:0]  emit_n_r;
  logic [BCW-1:0]  batch_r;
  logic            found_r, hit_r;
  logic [IDW-1:0]  cur_id_r;
  logic [EXPW-1:0] cur_exp_r, min_exp_r;
  epit_pkg::kind_t kind_r;
  logic [IDW-1:0]  rid_r;

  // Memory ports
  logic                       t_we;
  logic [TAW-1:0]             t_waddr, t_raddr;
  logic [epit_pkg::TWW-1:0]   t_wdata, t_rdata;
  logic                       s_we;
  logic [SAW-1:0]             s_waddr;
  logic [IDW-1:0]             s_rdata;
  logic                       e_we;
  logic [epit_pkg::EWW-1:0]   e_wdata, e_rdata;

  logic [IDW-1:0]  t_id;
  logic [EXPW-1:0] t_exp, exp_new;
  logic [SCW-1:0]  snap_base;
  logic            snap_fits, cfg_wr;

  assign t_id      = t_rdata[epit_pkg::TWW-1 -: IDW];
  assign t_exp     = t_rdata[EXPW-1:0];
  assign exp_new   = EXPW'(now_r) + EXPW'(life_r);
  assign snap_base = first_r ? '0 : snap_total_r;
  assign snap_fits = snap_base < SCW'(epit_pkg::SNAPSHOT_DEPTH);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];

  // Memory address and write selection
  always_comb begin
    t_raddr = cmd.rd_last ? TAW'(total_r - TCW'(1)) : idx_r;
    t_we    = 1'b0;
    t_waddr = found_idx_r;
    t_wdata = {id_r, exp_new};
    if (cmd.rec_commit) begin
      t_we = 1'b1;
      if (found_r) begin
        t_waddr = found_idx_r;
      end else if (total_r == TCW'(epit_pkg::TABLE_DEPTH)) begin
        t_waddr = min_idx_r;
      end else begin
        t_waddr = TAW'(total_r);
      end
    end else if (cmd.move) begin
      t_we    = 1'b1;
      t_waddr = found_idx_r;
      t_wdata = t_rdata;
    end
    s_we    = cmd.snap_load && snap_fits;
    s_waddr = SAW'(snap_base);
    e_we    = 1'b0;
    e_wdata = {1'b1, cur_id_r};
    if (cmd.decide) begin
      if (hit_r) begin
        e_we = batch_r < BCW'(epit_pkg::BATCH_MAX);
      end else begin
        e_we    = {1'b0, now_r} >= cur_exp_r;
        e_wdata = {1'b0, cur_id_r};
      end
    end
  end

  epit_ram #(.WIDTH(epit_pkg::TWW), .DEPTH(epit_pkg::TABLE_DEPTH)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  epit_ram #(.WIDTH(IDW), .DEPTH(epit_pkg::SNAPSHOT_DEPTH)) u_snap (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(id_r),
    .raddr(sidx_r), .rdata(s_rdata)
  );

  epit_ram #(.WIDTH(epit_pkg::EWW), .DEPTH(epit_pkg::TABLE_DEPTH)) u_emit (
    .clk(clk), .we(e_we), .waddr(TAW'(emit_n_r)), .wdata(e_wdata),
    .raddr(k_r), .rdata(e_rdata)
  );

  // Control registers: counts, lifetime, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      snap_total_r <= '0;
      life_r       <= epit_pkg::LIFETIME_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        life_r <= cfg_pwdata[epit_pkg::LIFEW-1:0];
      end
      if (cmd.snap_load) begin
        snap_total_r <= snap_fits ? snap_base + SCW'(1) : snap_base;
      end
      if (cmd.rec_commit && !found_r && total_r != TCW'(epit_pkg::TABLE_DEPTH)) begin
        total_r <= total_r + TCW'(1);
      end else if (cmd.move) begin
        total_r <= total_r - TCW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r      <= epit_pkg::op_t'(in_operation);
      id_r      <= in_item_id;
      cur_id_r  <= in_item_id;
      now_r     <= in_now_ms;
      first_r   <= in_snapshot_first;
      allowed_r <= in_pump_allowed;
      found_r   <= 1'b0;
    end
    if (cmd.set_res) begin
      kind_r <= cmd.res_kind;
      rid_r  <= '0;
    end
    if (cmd.snap_load) begin
      kind_r <= epit_pkg::K_LOADED;
      rid_r  <= id_r;
    end
    if (cmd.rec_commit) begin
      rid_r <= id_r;
      if (found_r) begin
        kind_r <= epit_pkg::K_REFRESHED;
      end else if (total_r == TCW'(epit_pkg::TABLE_DEPTH)) begin
        kind_r <= epit_pkg::K_REPLACED;
      end else begin
        kind_r <= epit_pkg::K_NEW;
      end
    end
    if (cmd.idx_clr || cmd.pump_init || cmd.rem_latch) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + TAW'(1);
    end
    if (cmd.min_upd && (idx_r == '0 || t_exp < min_exp_r)) begin
      min_exp_r <= t_exp;
      min_idx_r <= idx_r;
    end
    if (cmd.found_set) begin
      found_r     <= 1'b1;
      found_idx_r <= idx_r;
    end
    if (cmd.pump_init) begin
      emit_n_r <= '0;
      batch_r  <= '0;
    end
    if (e_we) begin
      emit_n_r <= emit_n_r + TCW'(1);
      if (hit_r) begin
        batch_r <= batch_r + BCW'(1);
      end
    end
    if (cmd.ent_latch) begin
      cur_id_r  <= t_id;
      cur_exp_r <= t_exp;
      sidx_r    <= '0;
      hit_r     <= 1'b0;
    end
    if (cmd.sidx_inc) begin
      sidx_r <= sidx_r + SAW'(1);
    end
    if (cmd.hit_set) begin
      hit_r <= 1'b1;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + TAW'(1);
    end
    if (cmd.rem_latch) begin
      cur_id_r <= e_rdata[IDW-1:0];
    end
    if (cmd.out_load) begin
      out_pending_count <= epit_pkg::CNTW'(total_r);
      out_last_result   <= cmd.out_last;
      if (cmd.out_emit) begin
        out_result_kind <= e_rdata[IDW] ? epit_pkg::K_DEPOSIT : epit_pkg::K_EXPIRED;
        out_result_id   <= e_rdata[IDW-1:0];
      end else begin
        out_result_kind <= kind_r;
        out_result_id   <= rid_r;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.op         = op_r;
    sts.id_zero    = id_r == '0;
    sts.allowed    = allowed_r;
    sts.total_zero = total_r == '0;
    sts.idx_last   = TCW'(idx_r) + TCW'(1) == total_r;
    sts.match      = t_id == cur_id_r;
    sts.smatch     = s_rdata == cur_id_r;
    sts.snap_empty = snap_total_r == '0;
    sts.sidx_last  = SCW'(sidx_r) + SCW'(1) == snap_total_r;
    sts.emit_empty = emit_n_r == '0;
    sts.k_last     = TCW'(k_r) + TCW'(1) == emit_n_r;
    sts.out_free   = !out_valid || out_ready;
  end

  assign cfg_prdata = cfg_paddr[2] ? '0 : epit_pkg::CFG_DW'(life_r);
endmodule

/* rtl/epit_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epit_ctrl
// Controller state machine: sequences record scans, pump walks, removals
// and result delivery through commands to the datapath.
// ----------------------------------------------------------------------------
module epit_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  epit_pkg::sts_t sts,
  output epit_pkg::cmd_t cmd
);
  typedef enum logic [20:0] {
    S_IDLE  = 21'd1 << 0,
    S_DISP  = 21'd1 << 1,
    S_RRD   = 21'd1 << 2,
    S_RCMP  = 21'd1 << 3,
    S_RDONE = 21'd1 << 4,
    S_RES   = 21'd1 << 5,
    S_PRD   = 21'd1 << 6,
    S_PLAT  = 21'd1 << 7,
    S_SRD   = 21'd1 << 8,
    S_SCMP  = 21'd1 << 9,
    S_PDEC  = 21'd1 << 10,
    S_PEND  = 21'd1 << 11,
    S_DRDE  = 21'd1 << 12,
    S_DLATE = 21'd1 << 13,
    S_DRD   = 21'd1 << 14,
    S_DCMP  = 21'd1 << 15,
    S_DLAST = 21'd1 << 16,
    S_DMOVE = 21'd1 << 17,
    S_ORDE  = 21'd1 << 18,
    S_OWAIT = 21'd1 << 19,
    S_SPARE = 21'd1 << 20
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_kind = epit_pkg::K_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          epit_pkg::OP_RECORD: begin
            if (sts.id_zero) begin
              cmd.set_res  = 1'b1;
              cmd.res_kind = epit_pkg::K_IGNORED;
              state_nxt    = S_RES;
            end else if (sts.total_zero) begin
              state_nxt = S_RDONE;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_RRD;
            end
          end
          epit_pkg::OP_SNAP: begin
            cmd.snap_load = 1'b1;
            state_nxt     = S_RES;
          end
          epit_pkg::OP_PUMP: begin
            if (sts.allowed && !sts.total_zero) begin
              cmd.pump_init = 1'b1;
              state_nxt     = S_PRD;
            end else begin
              cmd.set_res = 1'b1;
              state_nxt   = S_RES;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            state_nxt   = S_RES;
          end
        endcase
      end
      S_RRD: state_nxt = S_RCMP;
      S_RCMP: begin
        if (sts.match) begin
          cmd.found_set = 1'b1;
          state_nxt     = S_RDONE;
        end else begin
          cmd.min_upd = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_RDONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RRD;
          end
        end
      end
      S_RDONE: begin
        cmd.rec_commit = 1'b1;
        state_nxt      = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PRD: state_nxt = S_PLAT;
      S_PLAT: begin
        cmd.ent_latch = 1'b1;
        state_nxt     = sts.snap_empty ? S_PDEC : S_SRD;
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        if (sts.smatch) begin
          cmd.hit_set = 1'b1;
          state_nxt   = S_PDEC;
        end else if (sts.sidx_last) begin
          state_nxt = S_PDEC;
        end else begin
          cmd.sidx_inc = 1'b1;
          state_nxt    = S_SRD;
        end
      end
      S_PDEC: begin
        cmd.decide = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_PEND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_PRD;
        end
      end
      S_PEND: begin
        if (sts.emit_empty) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_RES;
        end else begin
          cmd.k_clr = 1'b1;
          state_nxt = S_DRDE;
        end
      end
      S_DRDE: state_nxt = S_DLATE;
      S_DLATE: begin
        cmd.rem_latch = 1'b1;
        state_nxt     = S_DRD;
      end
      S_DRD: state_nxt = S_DCMP;
      S_DCMP: begin
        if (sts.match || sts.idx_last) begin
          cmd.found_set = 1'b1;
          state_nxt     = S_DLAST;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_DRD;
        end
      end
      S_DLAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_DMOVE;
      end
      S_DMOVE: begin
        cmd.move = 1'b1;
        if (sts.k_last) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_ORDE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_DRDE;
        end
      end
      S_ORDE: state_nxt = S_OWAIT;
      S_OWAIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_emit = 1'b1;
          cmd.out_last = sts.k_last;
          if (sts.k_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_ORDE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* rtl/expiring_pending_id_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_pending_id_table
// Table of pending ids with expiry times, a snapshot list and a pump pass.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_ch.ready is high only while idle. A
// snapshot load or an ignored record goes from dispatch straight to the
// result. A record scans the table one entry at a time through the table
// RAM read port. A pump reads each entry and searches the snapshot RAM one
// snapshot entry at a time, then rescans the table for each emitted id for
// removal, then delivers the results one at a time. The lifetime register
// sits at byte address 0.
// ----------------------------------------------------------------------------
module expiring_pending_id_table (
  input  logic                        clk,
  input  logic                        rst_n,
  epit_in_if.sink                     in_ch,
  epit_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [epit_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [epit_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [epit_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  epit_pkg::cmd_t cmd;
  epit_pkg::sts_t sts;

  assign cfg_pready = 1'b1;

  epit_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  epit_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_ch.operation), .in_item_id(in_ch.item_id),
    .in_now_ms(in_ch.now_ms), .in_snapshot_first(in_ch.snapshot_first),
    .in_pump_allowed(in_ch.pump_allowed),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_result_kind(out_ch.result_kind), .out_result_id(out_ch.result_id),
    .out_pending_count(out_ch.pending_count),
    .out_last_result(out_ch.last_result)
  );
endmodule
